// File: rtl/core/edit_distance_engine_unit_defines.svh
// -----------------------------------------------------------------------------
// Edit distance engine assertion macros
// Shared concurrent check forms, clocked on clk and disabled during rst.
// -----------------------------------------------------------------------------
`ifndef EDIT_DISTANCE_ENGINE_UNIT_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define EDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define EDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/edd_pkg.sv
// -----------------------------------------------------------------------------
// Edit distance engine package
// Shared widths, command codes and the cell interface structs.
// -----------------------------------------------------------------------------
package edd_pkg;

  localparam int EDD_MAX_LEN = 64;   // default string length limit
  localparam int CHAR_W      = 16;   // character code unit
  localparam int CMD_W       = 2;
  localparam int OUT_DIST_W  = 7;    // reported distance width

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,   // load one pattern character
    CMD_STREAM = 2'd1,   // process one text character
    CMD_FINISH = 2'd2    // emit distance and clear
  } edd_cmd_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic              clear;
    logic              load;
    logic [CHAR_W-1:0] load_char;
  } edd_ctl_t;

  // Wavefront token moving one cell per cycle.
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
  } edd_tok_t;

endpackage

// File: rtl/core/edit_distance_engine_unit.sv
// -----------------------------------------------------------------------------
// Edit distance engine unit
// Levenshtein distance over 16-bit character strings on a systolic cell row.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, command, character): APPEND loads the
//   next pattern character into the first empty cell (before any STREAM),
//   STREAM pushes one text character into the cell row, FINISH emits the
//   distance and clears the engine. Unused command codes are taken and dropped.
//   Output channel (out_valid/out_stall, distance, overflow): one transfer per
//   FINISH. distance is the low 7 bits of the result.
// Throughput: APPEND and STREAM are taken every cycle. A text character walks
//   the row one cell per cycle, so FINISH is held off after the last STREAM
//   until the drain counter is zero and the wavefront has left the last cell.
// Latency: the result is valid the cycle after FINISH is taken.
// Stall: FINISH is held off while a result still waits in the output register;
//   APPEND and STREAM keep flowing meanwhile.
// Reset: rst clears all cells to column j = j at once; no sweep needed.
// Overflow: characters past MAX_LEN in either string are dropped and flagged.
// -----------------------------------------------------------------------------
`include "edit_distance_engine_unit_defines.svh"

module edit_distance_engine_unit import edd_pkg::*; #(
  parameter int MAX_LEN = EDD_MAX_LEN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      command,
  input  logic [CHAR_W-1:0]     character,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_DIST_W-1:0] distance,
  output logic                  overflow
);

  localparam int DW = $clog2(MAX_LEN + 1);   // distance / row count width
  localparam int CW = $clog2(MAX_LEN + 2);   // drain counter width
  localparam logic [DW-1:0] ROWS_MAX  = DW'(MAX_LEN);
  localparam logic [CW-1:0] DRAIN_LEN = CW'(MAX_LEN + 1);

  // Chain taps: index 0 is the head stage, index j is cell j.
  edd_tok_t      tok   [0:MAX_LEN];
  logic [DW-1:0] diag  [0:MAX_LEN];
  logic [DW-1:0] left  [0:MAX_LEN];
  logic          loaded[0:MAX_LEN];

  edd_ctl_t          ctl;
  edd_cmd_t          cmd;
  logic              in_fire;
  logic              out_fire;
  logic              out_busy;
  logic [DW-1:0]     rows_done;
  logic [DW-1:0]     last_dist;   // D[pattern_length] of the newest full row
  logic              overflow_seen;
  logic [CW-1:0]     drain;       // cycles until the row is quiet
  logic              head_valid;
  logic [CHAR_W-1:0] head_ch;
  logic [DW-1:0]     head_diag;   // old D[0] for the head transfer
  logic [DW-1:0]     head_left;   // new D[0] for the head transfer
  logic [DW+OUT_DIST_W-1:0] dist_ext;

  assign cmd      = edd_cmd_t'(command);
  assign out_busy = out_valid && out_stall;
  assign in_stall = (cmd == CMD_FINISH) && ((drain != '0) || out_busy);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign dist_ext = (DW + OUT_DIST_W)'(last_dist);

  // Broadcast control to the cells.
  always_comb begin
    ctl.clear     = in_fire && (cmd == CMD_FINISH);
    ctl.load      = in_fire && (cmd == CMD_APPEND) && (rows_done == '0);
    ctl.load_char = character;
  end

  assign loaded[0] = 1'b1;
  assign tok[0]    = '{valid: head_valid, ch: head_ch};
  assign diag[0]   = head_diag;
  assign left[0]   = head_left;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_done     <= '0;
      last_dist     <= '0;
      overflow_seen <= 1'b0;
      drain         <= '0;
      head_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      head_valid <= 1'b0;
      if (drain != '0) begin
        drain <= drain - 1'b1;
      end
      // Wavefront leaving the last cell carries D[pattern_length].
      if (tok[MAX_LEN].valid) begin
        last_dist <= left[MAX_LEN];
      end
      if (out_fire) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        case (cmd)
          CMD_APPEND: begin
            if (rows_done == '0) begin
              if (loaded[MAX_LEN]) begin
                overflow_seen <= 1'b1;
              end else begin
                last_dist <= last_dist + 1'b1;
              end
            end
          end
          CMD_STREAM: begin
            if (rows_done < ROWS_MAX) begin
              head_valid <= 1'b1;
              rows_done  <= rows_done + 1'b1;
              drain      <= DRAIN_LEN;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          CMD_FINISH: begin
            out_valid     <= 1'b1;
            rows_done     <= '0;
            last_dist     <= '0;
            overflow_seen <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: head stage and result.
  always_ff @(posedge clk) begin
    if (in_fire && (cmd == CMD_STREAM)) begin
      head_ch   <= character;
      head_diag <= rows_done;               // old D[0]
      head_left <= rows_done + 1'b1;        // new D[0]
    end
    if (in_fire && (cmd == CMD_FINISH)) begin
      distance <= dist_ext[OUT_DIST_W-1:0];
      overflow <= overflow_seen;
    end
  end

  // The cell row.
  for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
    edd_cell #(
      .DW  (DW),
      .IDX (j)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .prev_loaded (loaded[j-1]),
      .tok_in      (tok[j-1]),
      .diag_in     (diag[j-1]),
      .left_in     (left[j-1]),
      .loaded      (loaded[j]),
      .tok_out     (tok[j]),
      .diag_out    (diag[j]),
      .left_out    (left[j])
    );
  end

  // Checks.
  `EDD_ASSERT_NOW(a_finish_quiet, in_fire && (cmd == CMD_FINISH), drain == '0, "finish while row busy")
  `EDD_ASSERT_NEXT(a_finish_emits, in_fire && (cmd == CMD_FINISH), out_valid && (rows_done == '0), "finish did not emit and clear")
  `EDD_ASSERT_NOW(a_exit_in_drain, tok[MAX_LEN].valid, drain != '0, "wavefront outlived drain window")
  `EDD_ASSERT_NOW(a_rows_bound, 1'b1, rows_done <= ROWS_MAX, "row count past limit")

endmodule

// File: rtl/core/edd_cell.sv
// -----------------------------------------------------------------------------
// Edit distance cell
// Holds one pattern character and one distance column; updates the column
// when a text character passes and hands the result to the next cell.
// -----------------------------------------------------------------------------
module edd_cell import edd_pkg::*; #(
  parameter int DW  = 7,
  parameter int IDX = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  edd_ctl_t      ctl,
  input  logic          prev_loaded,
  input  edd_tok_t      tok_in,
  input  logic [DW-1:0] diag_in,
  input  logic [DW-1:0] left_in,
  output logic          loaded,
  output edd_tok_t      tok_out,
  output logic [DW-1:0] diag_out,
  output logic [DW-1:0] left_out
);

  localparam logic [DW-1:0] RESET_DIST = DW'(IDX);

  logic [CHAR_W-1:0] pchar;
  logic [DW-1:0]     col_dist;
  logic [DW-1:0]     col_dist_next;
  logic              tok_valid;
  logic [CHAR_W-1:0] tok_ch;
  logic [DW:0]       from_left;
  logic [DW:0]       from_up;
  logic [DW:0]       from_diag;
  logic [DW:0]       min_lu;
  logic [DW:0]       min_all;

  // Unit costs: insert, delete, substitute (free on a match).
  always_comb begin
    from_left     = {1'b0, left_in} + 1'b1;
    from_up       = {1'b0, col_dist} + 1'b1;
    from_diag     = {1'b0, diag_in} + {{DW{1'b0}}, (pchar != tok_in.ch)};
    min_lu        = (from_left < from_up) ? from_left : from_up;
    min_all       = (min_lu < from_diag) ? min_lu : from_diag;
    col_dist_next = min_all[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      loaded    <= 1'b0;
      col_dist  <= RESET_DIST;
      tok_valid <= 1'b0;
    end else begin
      if (ctl.load && prev_loaded && !loaded) begin
        loaded <= 1'b1;
      end
      if (tok_in.valid && loaded) begin
        col_dist <= col_dist_next;
      end
      tok_valid <= tok_in.valid;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (ctl.load && prev_loaded && !loaded) begin
      pchar <= ctl.load_char;
    end
    tok_ch <= tok_in.ch;
    if (loaded) begin
      diag_out <= col_dist;
      left_out <= col_dist_next;
    end else begin
      // Unused cell: pass the last real column on unchanged.
      diag_out <= diag_in;
      left_out <= left_in;
    end
  end

  assign tok_out = '{valid: tok_valid, ch: tok_ch};

endmodule
